// ----- hdl/rsc_pkg.sv -----
// Shared types and constants for the three-rotor substitution cipher.
`timescale 1ns / 1ps

package rsc_pkg;

    localparam int ALPHA_LEN = 26;

    localparam logic OPC_CIPHER = 1'b0;
    localparam logic OPC_LOAD   = 1'b1;

    localparam logic [1:0] ROTOR_FIRST  = 2'd0;
    localparam logic [1:0] ROTOR_SECOND = 2'd1;
    localparam logic [1:0] ROTOR_THIRD  = 2'd2;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    // One item as it travels down the rotor chain.
    typedef struct packed {
        logic       is_load;
        logic       is_letter;
        logic       is_lower;
        logic       carry;
        logic [4:0] value;
        logic [7:0] raw;
        logic [1:0] rotor_select;
        logic [4:0] entry_index;
        logic [4:0] entry_value;
    } rsc_item_t;

endpackage

// ----- hdl/rsc_rotor_cell.sv -----
// One rotor cell: a 26-entry table, its offset and one pipeline register.
`timescale 1ns / 1ps

module rsc_rotor_cell
    import rsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] cell_id,
    input  logic       up_valid,
    output logic       up_ready,
    input  rsc_item_t  up_item,
    output logic       dn_valid,
    input  logic       dn_ready,
    output rsc_item_t  dn_item,
    output logic [4:0] offset
);

    localparam logic [5:0] ALPHA_LEN6 = 6'(ALPHA_LEN);
    localparam logic [4:0] ALPHA_LEN5 = 5'(ALPHA_LEN);
    localparam logic [4:0] LAST_POS   = 5'(ALPHA_LEN - 1);

    logic [4:0] table_reg [0:ALPHA_LEN-1];
    logic [4:0] offset_reg;
    logic [4:0] offset_next;
    logic       valid_reg;
    rsc_item_t  item_reg;
    rsc_item_t  item_next;
    logic       accept;
    logic       wr_en;
    logic [5:0] sum;
    logic [5:0] wrap1;
    logic [5:0] wrap2;
    logic [4:0] pos;
    logic       at_last;

    assign up_ready = !valid_reg || dn_ready;
    assign accept   = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;
    assign offset   = offset_reg;
    assign at_last  = (offset_reg == LAST_POS);

    // The index can reach 31 + 25, so two conditional subtracts bring it into range.
    always_comb
    begin
        sum   = {1'b0, up_item.value} + {1'b0, offset_reg};
        wrap1 = (sum >= ALPHA_LEN6) ? sum - ALPHA_LEN6 : sum;
        wrap2 = (wrap1 >= ALPHA_LEN6) ? wrap1 - ALPHA_LEN6 : wrap1;
        pos   = wrap2[4:0];
    end

    assign wr_en = accept && up_item.is_load && (up_item.rotor_select == cell_id)
                   && (up_item.entry_index < ALPHA_LEN5);

    always_comb
    begin
        item_next   = up_item;
        offset_next = offset_reg;
        if (up_item.is_load)
        begin
            offset_next = '0;
        end
        else if (up_item.is_letter)
        begin
            item_next.value = table_reg[pos];
            item_next.carry = up_item.carry && at_last;
            if (up_item.carry)
            begin
                offset_next = at_last ? 5'd0 : offset_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_reg[up_item.entry_index] <= up_item.entry_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            offset_reg <= '0;
        end
        else
        begin
            if (up_ready)
            begin
                valid_reg <= up_valid;
            end
            if (accept)
            begin
                offset_reg <= offset_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- hdl/three_rotor_substitution_cipher_top.sv -----
// Top level of the three-rotor substitution cipher: input decode, rotor chain, output.
`timescale 1ns / 1ps

// The block takes one item per clock cycle unless out_ready stalls the chain, either
// a cipher byte or a rotor table load. The item passes the registers of three rotor
// cells in turn; each cell holds its own 26-entry table and offset and steps that
// offset when the carry that rides along with the letter reaches it, so the
// odometer needs no feedback and the chain stays full. A load occupies one slot
// like any other item, writes its entry as it passes the selected cell, clears
// every offset on the way and gives no result. The third cell's register holds the
// result; while it waits, the earlier cells keep taking items until full.

module three_rotor_substitution_cipher_top
    import rsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] data_byte,
    input  logic [1:0] rotor_select,
    input  logic [4:0] entry_index,
    input  logic [4:0] entry_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);

    rsc_item_t  in_item;
    rsc_item_t  c1_item;
    rsc_item_t  c2_item;
    rsc_item_t  c3_item;
    logic       c1_valid;
    logic       c2_valid;
    logic       c3_valid;
    logic       c1_ready;
    logic       c2_ready;
    logic       c3_ready;
    logic [4:0] c1_off;
    logic [4:0] c2_off;
    logic [4:0] c3_off;
    logic       is_upper;
    logic       is_lower;
    logic [7:0] base;

    always_comb
    begin
        is_upper = (data_byte >= CHAR_UPPER_A) && (data_byte <= CHAR_UPPER_Z);
        is_lower = (data_byte >= CHAR_LOWER_A) && (data_byte <= CHAR_LOWER_Z);
        base     = is_lower ? CHAR_LOWER_A : CHAR_UPPER_A;

        in_item              = '0;
        in_item.is_load      = (opcode == OPC_LOAD);
        in_item.is_letter    = (opcode == OPC_CIPHER) && (is_upper || is_lower);
        in_item.is_lower     = is_lower;
        in_item.carry        = in_item.is_letter;
        in_item.value        = 5'(data_byte - base);
        in_item.raw          = data_byte;
        in_item.rotor_select = rotor_select;
        in_item.entry_index  = entry_index;
        in_item.entry_value  = entry_value;
    end

    rsc_rotor_cell u_cell1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_id  (ROTOR_FIRST),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_item  (in_item),
        .dn_valid (c1_valid),
        .dn_ready (c1_ready),
        .dn_item  (c1_item),
        .offset   (c1_off)
    );

    rsc_rotor_cell u_cell2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_id  (ROTOR_SECOND),
        .up_valid (c1_valid),
        .up_ready (c1_ready),
        .up_item  (c1_item),
        .dn_valid (c2_valid),
        .dn_ready (c2_ready),
        .dn_item  (c2_item),
        .offset   (c2_off)
    );

    rsc_rotor_cell u_cell3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_id  (ROTOR_THIRD),
        .up_valid (c2_valid),
        .up_ready (c2_ready),
        .up_item  (c2_item),
        .dn_valid (c3_valid),
        .dn_ready (c3_ready),
        .dn_item  (c3_item),
        .offset   (c3_off)
    );

    // Load items retire silently at the end of the chain.
    assign out_valid = c3_valid && !c3_item.is_load;
    assign c3_ready  = out_ready || c3_item.is_load;

    always_comb
    begin
        if (c3_item.is_letter)
        begin
            out_byte = (c3_item.is_lower ? CHAR_LOWER_A : CHAR_UPPER_A) + {3'b000, c3_item.value};
        end
        else
        begin
            out_byte = c3_item.raw;
        end
    end

    a_offsets_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (c1_off <= 5'(ALPHA_LEN - 1)) && (c2_off <= 5'(ALPHA_LEN - 1))
        && (c3_off <= 5'(ALPHA_LEN - 1)))
        else $error("rotor offset out of range");

    a_load_clears_first: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode == OPC_LOAD)) |=> (c1_off == 5'd0))
        else $error("load did not clear the first offset");

    a_letter_steps_first: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.is_letter) |=>
        (c1_off == (($past(c1_off) == 5'(ALPHA_LEN - 1)) ? 5'd0 : $past(c1_off) + 5'd1)))
        else $error("letter did not step the first offset");

endmodule

// ----- dv/three_rotor_substitution_cipher_top_tb.sv -----
// Self-checking testbench for the three-rotor substitution cipher top level.
`timescale 1ns / 1ps

module three_rotor_substitution_cipher_top_tb;

    import rsc_pkg::*;

    localparam logic [1:0] ROTOR_NONE = 2'd3;
    localparam int MAX_REPORTED       = 10;
    localparam int STALL_LIMIT        = 2000;
    localparam int DRAIN_CYCLES       = 10;
    localparam int RANDOM_ITEMS       = 320;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    logic [7:0] data_byte;
    logic [1:0] rotor_select;
    logic [4:0] entry_index;
    logic [4:0] entry_value;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;

    // Shadow copy of the rotor tables and the odometer.
    logic [4:0] rotor_mem [0:2][0:ALPHA_LEN-1];
    logic [4:0] first_pos;
    logic [4:0] second_pos;
    logic [4:0] third_pos;

    logic [7:0] expected_out_bytes [$];
    int         fail_count = 0;
    int         quiet_cycles;
    int         rx_stall_left;
    bit         tx_idle_on;
    bit         rx_idle_on;

    three_rotor_substitution_cipher_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .rotor_select (rotor_select),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                return 0;
            else if (roll < 90)
                return $urandom_range(1, 3);
            else if (roll < 98)
                return $urandom_range(4, 10);
            else
                return $urandom_range(20, 60);
        end
    endfunction

    function automatic logic [4:0] rotor_read(input int rotor, input logic [4:0] idx,
                                              input logic [4:0] off);
        int pos;
        begin
            pos = (int'(idx) + int'(off)) % ALPHA_LEN;
            return rotor_mem[rotor][pos];
        end
    endfunction

    // Updates the shadow state for one accepted item and, for a cipher byte, queues its output byte.
    task automatic rotor_chain_predict(input logic op, input logic [7:0] data,
                                       input logic [1:0] sel, input logic [4:0] idx,
                                       input logic [4:0] val);
        logic [7:0] base;
        logic [4:0] v;
        begin
            if (op == OPC_LOAD)
            begin
                if (sel != ROTOR_NONE && idx < ALPHA_LEN)
                    rotor_mem[sel][idx] = val;
                first_pos  = '0;
                second_pos = '0;
                third_pos  = '0;
            end
            else if ((data >= CHAR_UPPER_A && data <= CHAR_UPPER_Z) ||
                     (data >= CHAR_LOWER_A && data <= CHAR_LOWER_Z))
            begin
                base = (data >= CHAR_LOWER_A) ? CHAR_LOWER_A : CHAR_UPPER_A;
                v = 5'(data - base);
                v = rotor_read(0, v, first_pos);
                v = rotor_read(1, v, second_pos);
                v = rotor_read(2, v, third_pos);
                expected_out_bytes.push_back(8'(base + 8'(v)));
                if (first_pos == ALPHA_LEN - 1)
                begin
                    first_pos = '0;
                    if (second_pos == ALPHA_LEN - 1)
                    begin
                        second_pos = '0;
                        third_pos = (third_pos == ALPHA_LEN - 1) ? 5'd0 : third_pos + 5'd1;
                    end
                    else
                        second_pos = second_pos + 5'd1;
                end
                else
                    first_pos = first_pos + 5'd1;
            end
            else
                expected_out_bytes.push_back(data);
        end
    endtask

    // Called at a rising edge; returns at the edge where the item is accepted.
    task automatic send_item(input logic op, input logic [7:0] data, input logic [1:0] sel,
                             input logic [4:0] idx, input logic [4:0] val);
        int gap;
        begin
            gap = tx_idle_on ? idle_gap() : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid     <= 1'b1;
            opcode       <= op;
            data_byte    <= data;
            rotor_select <= sel;
            entry_index  <= idx;
            entry_value  <= val;
            do
                @(posedge clk);
            while (!in_ready);
            rotor_chain_predict(op, data, sel, idx, val);
        end
    endtask

    task automatic send_byte(input logic [7:0] data);
        begin
            send_item(OPC_CIPHER, data, 2'($urandom()), 5'($urandom()), 5'($urandom()));
        end
    endtask

    task automatic send_load(input logic [1:0] sel, input logic [4:0] idx,
                             input logic [4:0] val);
        begin
            send_item(OPC_LOAD, 8'($urandom()), sel, idx, val);
        end
    endtask

    function automatic logic [7:0] random_letter();
        begin
            if ($urandom_range(0, 1) == 0)
                return CHAR_UPPER_A + 8'($urandom_range(0, ALPHA_LEN - 1));
            else
                return CHAR_LOWER_A + 8'($urandom_range(0, ALPHA_LEN - 1));
        end
    endfunction

    // Non-letters read no table, so they are safe before anything is loaded.
    task automatic test_passthrough_unloaded();
        begin
            send_byte(8'h00);
            send_byte(8'hFF);
            send_byte(CHAR_UPPER_A - 8'd1);
            send_byte(CHAR_UPPER_Z + 8'd1);
            send_byte(CHAR_LOWER_A - 8'd1);
            send_byte(CHAR_LOWER_Z + 8'd1);
            send_byte(8'h7F);
            send_byte(8'h80);
        end
    endtask

    // Every entry gets written; some values lie above the alphabet range.
    task automatic test_load_all_rotors();
        begin
            for (int r = 0; r < 3; r++)
                for (int i = 0; i < ALPHA_LEN; i++)
                    send_load(2'(r), 5'(i), 5'((i * 7 + r * 3 + 5) % 32));
            send_load(ROTOR_THIRD, 5'd25, 5'd31);
            send_load(ROTOR_FIRST, 5'd0, 5'd31);
        end
    endtask

    task automatic test_letter_extremes();
        begin
            send_byte(CHAR_UPPER_A);
            send_byte(CHAR_UPPER_Z);
            send_byte(CHAR_LOWER_A);
            send_byte(CHAR_LOWER_Z);
            send_byte(CHAR_UPPER_Z);
            send_byte(CHAR_LOWER_A);
        end
    endtask

    // Ignored loads must still clear the odometer.
    task automatic test_ignored_loads();
        begin
            send_byte(CHAR_UPPER_A);
            send_load(ROTOR_NONE, 5'd3, 5'd9);
            send_byte(CHAR_UPPER_A);
            send_byte(CHAR_LOWER_Z);
            send_load(ROTOR_SECOND, 5'd31, 5'd0);
            send_byte(CHAR_UPPER_A);
            send_load(ROTOR_THIRD, 5'd26, 5'd17);
            send_byte(CHAR_LOWER_A);
        end
    endtask

    // Two full turns of the first offset, carrying into the second, with non-letters
    // mixed in that must not step it.
    task automatic test_odometer_full_turn();
        begin
            send_load(ROTOR_FIRST, 5'd1, 5'($urandom()));
            for (int n = 0; n < ALPHA_LEN * 2 + 5; n++)
            begin
                if (n % 9 == 0)
                    send_byte(8'h20);
                send_byte(random_letter());
            end
        end
    endtask

    task automatic test_random_traffic();
        int roll;
        int run_len;
        int sent;
        begin
            sent = 0;
            while (sent < RANDOM_ITEMS)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
                run_len = $urandom_range(1, 80);
                for (int n = 0; n < run_len && sent < RANDOM_ITEMS; n++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 65)
                        send_byte(random_letter());
                    else if (roll < 85)
                        send_byte(8'($urandom_range(0, 255)));
                    else if (roll < 96)
                        send_load(2'($urandom_range(0, 2)), 5'($urandom_range(0, 25)),
                                  5'($urandom()));
                    else
                        send_load(2'($urandom()), 5'($urandom()), 5'($urandom()));
                    sent++;
                end
            end
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
        end
    endtask

    // Output side: random back-pressure and the result check.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            rx_stall_left  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_out_bytes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTED)
                        $display("unexpected output item: out_byte=%02h", out_byte);
                end
                else
                begin
                    logic [7:0] want;
                    want = expected_out_bytes.pop_front();
                    if (out_byte !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTED)
                            $display("out_byte mismatch: expected %02h, got %02h",
                                     want, out_byte);
                    end
                end
            end
            if (rx_stall_left != 0)
            begin
                out_ready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 99) < 25)
                    rx_stall_left = idle_gap();
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("three_rotor_substitution_cipher_top: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OPC_CIPHER;
        data_byte    = '0;
        rotor_select = ROTOR_FIRST;
        entry_index  = '0;
        entry_value  = '0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        first_pos    = '0;
        second_pos   = '0;
        third_pos    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough_unloaded();
        test_load_all_rotors();
        test_letter_extremes();
        test_ignored_loads();
        test_odometer_full_turn();
        test_random_traffic();

        in_valid <= 1'b0;
        while (expected_out_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("three_rotor_substitution_cipher_top: match");
        else
            $display("three_rotor_substitution_cipher_top: mismatch");
        $finish;
    end

endmodule

// ----- three_rotor_substitution_cipher_top.f -----
hdl/rsc_pkg.sv
hdl/rsc_rotor_cell.sv
hdl/three_rotor_substitution_cipher_top.sv
dv/three_rotor_substitution_cipher_top_tb.sv
